FILE: rtl/core/lbp_pkg.sv
package lbp_pkg;

   localparam int MAX_WIDTH   = 4096;
   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int PIX_W       = 8;
   localparam int IMG_W_W     = 13;
   localparam int IMG_H_W     = 16;
   localparam int WCMP_W      = IMG_W_W + 1;
   localparam int PEND_W      = $clog2(MAX_WIDTH + 2);
   localparam int CSR_DATA_W  = 16;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [IMG_W_W-1:0] WIDTH_RESET  = IMG_W_W'(4032);
   localparam logic [IMG_H_W-1:0] HEIGHT_RESET = IMG_H_W'(3024);

   typedef enum logic {
      OP_PIXEL = 1'b0,
      OP_DRAIN = 1'b1
   } opcode_type;

   typedef enum logic {
      REG_IMAGE_WIDTH  = 1'b0,
      REG_IMAGE_HEIGHT = 1'b1
   } reg_index_type;

   typedef logic [PIX_W-1:0] pixel_type;

   // one classified item handed from the front to the back
   typedef struct packed {
      pixel_type        pixel;
      logic [COL_W-1:0] col;
      logic             emit;
      logic             left_edge;
      logic             right_edge;
      logic             top_edge;
      logic             bottom_edge;
      logic             last;
   } work_type;

endpackage

FILE: rtl/core/lbp_req_if.sv
interface lbp_req_if;
   logic                valid;
   logic                ready;
   lbp_pkg::opcode_type opcode;
   lbp_pkg::pixel_type  pixel_value;

   modport source (output valid, output opcode, output pixel_value, input ready);
   modport sink   (input valid, input opcode, input pixel_value, output ready);
endinterface

FILE: rtl/core/lbp_rsp_if.sv
interface lbp_rsp_if;
   logic               valid;
   logic               ready;
   lbp_pkg::pixel_type lbp_code;
   logic               end_of_frame;

   modport source (output valid, output lbp_code, output end_of_frame, input ready);
   modport sink   (input valid, input lbp_code, input end_of_frame, output ready);
endinterface

FILE: rtl/core/lbp_csr_if.sv
interface lbp_csr_if;
   logic                                valid;
   logic                                ready;
   lbp_pkg::reg_index_type              index;
   logic [lbp_pkg::CSR_DATA_W-1:0]      data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/lbp_front.sv
module lbp_front (
   input  logic              clock,
   input  logic              reset,
   lbp_req_if.sink           req_ch,
   lbp_csr_if.sink           csr_ch,
   input  logic              q_full,
   output logic              q_push,
   output lbp_pkg::work_type q_data
);
   import lbp_pkg::*;

   logic [IMG_W_W-1:0] width_ff, width_in;
   logic [IMG_H_W-1:0] height_ff, height_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [IMG_H_W-1:0] row_ff, row_in;
   logic [PEND_W-1:0]  pend_ff, pend_in;

   logic [IMG_W_W-1:0] w_eff;
   logic [IMG_H_W-1:0] h_eff;
   logic [WCMP_W-1:0]  w_ext;
   logic [COL_W-1:0]   col;
   logic [COL_W-1:0]   ccol;
   logic               col_wrap;
   logic               take;
   logic               drain;
   logic               emit;
   logic               right_edge;
   logic               bottom_edge;
   logic               last;

   assign csr_ch.ready = 1'b1;
   assign req_ch.ready = !q_full;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            REG_IMAGE_WIDTH:  width_in  = csr_ch.data[IMG_W_W-1:0];
            REG_IMAGE_HEIGHT: height_in = csr_ch.data[IMG_H_W-1:0];
            default:          width_in  = width_ff;
         endcase
      end
   end

   // clamp out-of-range register values
   always_comb begin
      if (width_ff == '0) begin
         w_eff = IMG_W_W'(1);
      end else if (width_ff > IMG_W_W'(MAX_WIDTH)) begin
         w_eff = IMG_W_W'(MAX_WIDTH);
      end else begin
         w_eff = width_ff;
      end
      h_eff = (height_ff == '0) ? IMG_H_W'(1) : height_ff;
   end

   assign w_ext       = WCMP_W'(w_eff);
   assign col         = (WCMP_W'(col_ff) >= w_ext) ? '0 : col_ff;
   assign col_wrap    = (WCMP_W'(col) + WCMP_W'(1)) >= w_ext;
   assign ccol        = (col == '0) ? COL_W'(w_eff - IMG_W_W'(1)) : col - COL_W'(1);
   assign right_edge  = WCMP_W'(ccol) >= (w_ext - WCMP_W'(1));
   assign bottom_edge = row_ff >= (h_eff - IMG_H_W'(1));
   assign emit        = WCMP_W'(pend_ff) >= (w_ext + WCMP_W'(1));
   assign last        = right_edge && bottom_edge;

   assign take   = req_ch.valid && req_ch.ready;
   assign drain  = (req_ch.opcode == OP_DRAIN);
   // drop a drain item when nothing is pending
   assign q_push = take && !(drain && pend_ff == '0);

   always_comb begin
      q_data.pixel       = drain ? '0 : req_ch.pixel_value;
      q_data.col         = col;
      q_data.emit        = emit;
      q_data.left_edge   = (ccol == '0);
      q_data.right_edge  = right_edge;
      q_data.top_edge    = (row_ff == '0);
      q_data.bottom_edge = bottom_edge;
      q_data.last        = last;
   end

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      pend_in = pend_ff;
      if (q_push) begin
         col_in = col_wrap ? '0 : col + COL_W'(1);
         if (!emit) begin
            pend_in = pend_ff + PEND_W'(1);
         end else if (last) begin
            row_in  = '0;
            col_in  = '0;
            pend_in = '0;
         end else if (right_edge) begin
            row_in = row_ff + IMG_H_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         col_ff    <= '0;
         row_ff    <= '0;
         pend_ff   <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         pend_ff   <= pend_in;
      end
   end

endmodule

FILE: rtl/core/lbp_queue.sv
module lbp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  lbp_pkg::work_type push_data,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output lbp_pkg::work_type head_data
);
   import lbp_pkg::*;

   work_type            slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push;
   logic                do_pop;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = slot_ff[rd_ptr_ff];

   assign do_push = push && !full;
   assign do_pop  = pop && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: rtl/core/lbp_back.sv
module lbp_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  lbp_pkg::work_type q_data,
   output logic              q_pop,
   lbp_rsp_if.source         rsp_ch
);
   import lbp_pkg::*;

   localparam logic [PIX_W-1:0] WT_TOP_LEFT  = PIX_W'(32);
   localparam logic [PIX_W-1:0] WT_TOP       = PIX_W'(64);
   localparam logic [PIX_W-1:0] WT_TOP_RIGHT = PIX_W'(128);
   localparam logic [PIX_W-1:0] WT_RIGHT     = PIX_W'(1);
   localparam logic [PIX_W-1:0] WT_BOT_RIGHT = PIX_W'(2);
   localparam logic [PIX_W-1:0] WT_BOT       = PIX_W'(4);
   localparam logic [PIX_W-1:0] WT_BOT_LEFT  = PIX_W'(8);
   localparam logic [PIX_W-1:0] WT_LEFT      = PIX_W'(16);

   // row store: upper byte two rows back, lower byte one row back
   logic [2*PIX_W-1:0] row_mem [MAX_WIDTH];
   logic [2*PIX_W-1:0] rd_raw;
   logic [2*PIX_W-1:0] byp_data;
   logic               byp_ff, byp_in;

   logic               s1_vld_ff, s1_vld_in;
   work_type           s1_ff, s1_in;
   pixel_type          win1_ff [3];
   pixel_type          win2_ff [3];
   pixel_type          win1_in [3];
   pixel_type          win2_in [3];
   logic               rsp_vld_ff, rsp_vld_in;
   pixel_type          code_ff, code_in;
   logic               eof_ff, eof_in;

   logic               back_en;
   logic               retire;
   logic [2*PIX_W-1:0] wr_data;
   pixel_type          top_px;
   pixel_type          mid_px;
   pixel_type          win [3][3];
   pixel_type          center;
   logic [1:0]         li, ri, ti, bi;
   pixel_type          code;

   assign back_en = !rsp_vld_ff || rsp_ch.ready;
   assign q_pop   = back_en && q_valid;
   assign retire  = back_en && s1_vld_ff;

   assign top_px  = byp_ff ? byp_data[2*PIX_W-1:PIX_W] : rd_raw[2*PIX_W-1:PIX_W];
   assign mid_px  = byp_ff ? byp_data[PIX_W-1:0] : rd_raw[PIX_W-1:0];
   assign wr_data = {mid_px, s1_ff.pixel};

   // forward the entry being written when the next item reads the same column
   assign byp_in = retire && (s1_ff.col == q_data.col);

   always_ff @(posedge clock) begin
      if (retire) begin
         row_mem[s1_ff.col] <= wr_data;
      end
      if (q_pop) begin
         rd_raw   <= row_mem[q_data.col];
         byp_data <= wr_data;
      end
   end

   // window after the shift: column 0 oldest, row 0 top
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         win[0][r] = win1_ff[r];
         win[1][r] = win2_ff[r];
      end
      win[2][0] = top_px;
      win[2][1] = mid_px;
      win[2][2] = s1_ff.pixel;
   end

   always_comb begin
      center = win[1][1];
      li     = s1_ff.left_edge ? 2'd1 : 2'd0;
      ri     = s1_ff.right_edge ? 2'd1 : 2'd2;
      ti     = s1_ff.top_edge ? 2'd1 : 2'd0;
      bi     = s1_ff.bottom_edge ? 2'd1 : 2'd2;
      code   = '0;
      if (win[li][ti] > center) code = code | WT_TOP_LEFT;
      if (win[1][ti]  > center) code = code | WT_TOP;
      if (win[ri][ti] > center) code = code | WT_TOP_RIGHT;
      if (win[ri][1]  > center) code = code | WT_RIGHT;
      if (win[ri][bi] > center) code = code | WT_BOT_RIGHT;
      if (win[1][bi]  > center) code = code | WT_BOT;
      if (win[li][bi] > center) code = code | WT_BOT_LEFT;
      if (win[li][1]  > center) code = code | WT_LEFT;
   end

   always_comb begin
      s1_vld_in  = s1_vld_ff;
      s1_in      = s1_ff;
      rsp_vld_in = rsp_vld_ff;
      code_in    = code_ff;
      eof_in     = eof_ff;
      for (int r = 0; r < 3; r++) begin
         win1_in[r] = win1_ff[r];
         win2_in[r] = win2_ff[r];
      end
      if (back_en) begin
         s1_vld_in  = q_valid;
         s1_in      = q_data;
         rsp_vld_in = s1_vld_ff && s1_ff.emit;
         code_in    = code;
         eof_in     = s1_ff.last;
      end
      if (retire) begin
         for (int r = 0; r < 3; r++) begin
            win1_in[r] = win2_ff[r];
            win2_in[r] = win[2][r];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
         byp_ff     <= 1'b0;
         for (int r = 0; r < 3; r++) begin
            win1_ff[r] <= '0;
            win2_ff[r] <= '0;
         end
      end else begin
         s1_vld_ff  <= s1_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         if (q_pop) begin
            byp_ff <= byp_in;
         end
         for (int r = 0; r < 3; r++) begin
            win1_ff[r] <= win1_in[r];
            win2_ff[r] <= win2_in[r];
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_ff   <= s1_in;
      code_ff <= code_in;
      eof_ff  <= eof_in;
   end

   assign rsp_ch.valid        = rsp_vld_ff;
   assign rsp_ch.lbp_code     = code_ff;
   assign rsp_ch.end_of_frame = eof_ff;

endmodule

FILE: rtl/core/lbp_3x3_clamped_stream.sv
// 3x3 local binary pattern over a raster stream of 8-bit pixels. Send one item per
// pixel; after the last pixel of a frame send image_width+1 drain items, and the code
// of the last pixel comes out with end_of_frame set. Codes lag the input by
// image_width+1 items. The block takes one item every clock while results are taken:
// the front tracks column, row and pending counts and tags each item, a four-entry
// queue decouples it from the back, which reads the two-row store (one 4096 x 16
// memory, one write and one registered read per clock) and forms the code into an
// output register. An accepted item passes through the queue and the back's stage
// register before the code it completes is registered. Write image_width and
// image_height only while the block is idle.
module lbp_3x3_clamped_stream (
   input  logic clock,
   input  logic reset,
   lbp_req_if.sink   req_ch,
   lbp_rsp_if.source rsp_ch,
   lbp_csr_if.sink   csr_ch
);
   import lbp_pkg::*;

   logic     q_push;
   logic     q_full;
   logic     q_pop;
   logic     q_valid;
   work_type push_data;
   work_type head_data;

   lbp_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .csr_ch (csr_ch),
      .q_full (q_full),
      .q_push (q_push),
      .q_data (push_data)
   );

   lbp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (push_data),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_data  (head_data)
   );

   lbp_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_data  (head_data),
      .q_pop   (q_pop),
      .rsp_ch  (rsp_ch)
   );

endmodule

FILE: tb/lbp_3x3_clamped_stream_test.sv
module lbp_3x3_clamped_stream_test;
   import lbp_pkg::*;

   typedef struct packed {
      pixel_type code;
      logic      eof;
   } lbp_result_type;

   class lbp_code_tracker;
      logic [IMG_W_W-1:0] width_reg;
      logic [IMG_H_W-1:0] height_reg;
      pixel_type          above_row [MAX_WIDTH];
      pixel_type          this_row [MAX_WIDTH];
      pixel_type          win [3][3];   // [column: 0 oldest][row: 0 top]
      logic [COL_W-1:0]   col_pos;
      logic [IMG_H_W-1:0] row_pos;
      logic [PEND_W-1:0]  backlog;
      lbp_result_type     codes_due [$];
      int                 errors;

      function new();
         width_reg = WIDTH_RESET;
         height_reg = HEIGHT_RESET;
         foreach (above_row[i]) begin
            above_row[i] = '0;
            this_row[i] = '0;
         end
         foreach (win[i, j]) win[i][j] = '0;
         col_pos = '0;
         row_pos = '0;
         backlog = '0;
         errors = 0;
      endfunction

      function void set_reg(reg_index_type idx, logic [CSR_DATA_W-1:0] value);
         if (idx == REG_IMAGE_WIDTH) width_reg = value[IMG_W_W-1:0];
         else height_reg = value[IMG_H_W-1:0];
      endfunction

      function int eff_width();
         int w;
         w = width_reg;
         if (w < 1) w = 1;
         if (w > MAX_WIDTH) w = MAX_WIDTH;
         return w;
      endfunction

      function int eff_height();
         return (height_reg == 0) ? 1 : int'(height_reg);
      endfunction

      function bit frame_open();
         return backlog != 0;
      endfunction

      // advance the window by one accepted item and queue the code it completes
      function void note_item(opcode_type op, pixel_type px);
         int             w, h, col, ccol, li, ri, ti, bi;
         pixel_type      x, top, mid, c;
         lbp_result_type res;
         w = eff_width();
         h = eff_height();
         if (op == OP_DRAIN && backlog == 0) return;
         x = (op == OP_DRAIN) ? '0 : px;
         col = col_pos;
         if (col >= w) col = 0;
         top = above_row[col];
         mid = this_row[col];
         above_row[col] = mid;
         this_row[col] = x;
         for (int k = 0; k < 3; k++) begin
            win[0][k] = win[1][k];
            win[1][k] = win[2][k];
         end
         win[2][0] = top;
         win[2][1] = mid;
         win[2][2] = x;
         col_pos = (col + 1 >= w) ? '0 : COL_W'(col + 1);
         if (int'(backlog) < w + 1) begin
            backlog = backlog + 1'b1;
            return;
         end
         ccol = (col == 0) ? w - 1 : col - 1;
         li = (ccol == 0) ? 1 : 0;
         ri = (ccol >= w - 1) ? 1 : 2;
         ti = (row_pos == 0) ? 1 : 0;
         bi = (int'(row_pos) >= h - 1) ? 1 : 2;
         c = win[1][1];
         res.code[5] = win[li][ti] > c;
         res.code[6] = win[1][ti] > c;
         res.code[7] = win[ri][ti] > c;
         res.code[0] = win[ri][1] > c;
         res.code[1] = win[ri][bi] > c;
         res.code[2] = win[1][bi] > c;
         res.code[3] = win[li][bi] > c;
         res.code[4] = win[li][1] > c;
         res.eof = (ccol >= w - 1) && (int'(row_pos) >= h - 1);
         if (res.eof) begin
            row_pos = '0;
            col_pos = '0;
            backlog = '0;
         end else if (ccol >= w - 1) begin
            row_pos = row_pos + 1'b1;
         end
         codes_due.push_back(res);
      endfunction

      task report(string what);
         errors++;
         if (errors <= 200) $display("mismatch: %s", what);
      endtask

      task check_code(pixel_type code, logic eof);
         lbp_result_type want;
         if (codes_due.size() == 0) begin
            report($sformatf("unexpected code %0d eof %0b", code, eof));
            return;
         end
         want = codes_due.pop_front();
         if (code !== want.code)
            report($sformatf("lbp_code %0d, want %0d", code, want.code));
         if (eof !== want.eof)
            report($sformatf("end_of_frame %0b, want %0b", eof, want.eof));
      endtask
   endclass

   logic clock;
   logic reset;

   lbp_req_if req_bus();
   lbp_rsp_if rsp_bus();
   lbp_csr_if csr_bus();

   lbp_3x3_clamped_stream u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   lbp_code_tracker tracker = new();
   int              idle_pct = 38;
   pixel_type       flat_level = '0;
   bit              pause_due = 1'b1;
   int              random_items = 0;

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(0, 99) >= idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         tracker.check_code(rsp_bus.lbp_code, rsp_bus.end_of_frame);
   end

   function automatic pixel_type pick_pixel();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         2, 3: return flat_level + 8'($urandom_range(0, 2));
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic send_item(opcode_type op, pixel_type px);
      @(negedge clock);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.opcode <= op;
      req_bus.pixel_value <= px;
      do @(posedge clock); while (!req_bus.ready);
      tracker.note_item(op, px);
   endtask

   task automatic hold_req();
      @(negedge clock);
      req_bus.valid <= 1'b0;
   endtask

   task automatic wait_drained();
      hold_req();
      while (tracker.codes_due.size() != 0) @(posedge clock);
   endtask

   // items that give no code may still be in flight after the last code
   task automatic quiesce();
      wait_drained();
      repeat (10) @(posedge clock);
   endtask

   task automatic write_reg(reg_index_type idx, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data <= value;
      do @(posedge clock); while (!csr_bus.ready);
      tracker.set_reg(idx, value);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic set_frame(logic [CSR_DATA_W-1:0] w, logic [CSR_DATA_W-1:0] h);
      write_reg(REG_IMAGE_WIDTH, w);
      write_reg(REG_IMAGE_HEIGHT, h);
   endtask

   // one full frame; rough frames mix in early drains and pixels while draining
   task automatic run_frame(bit rough);
      int         w, h, sent;
      opcode_type op;
      w = tracker.eff_width();
      h = tracker.eff_height();
      flat_level = 8'($urandom);
      sent = 0;
      do begin
         if (sent < w * h)
            op = (rough && sent != 0 && $urandom_range(0, 99) < 5) ? OP_DRAIN : OP_PIXEL;
         else
            op = (rough && $urandom_range(0, 99) < 10) ? OP_PIXEL : OP_DRAIN;
         if ((pause_due && sent == (w * h) / 2) || $urandom_range(0, 199) == 0) begin
            wait_drained();
            pause_due = 1'b0;
         end
         send_item(op, pick_pixel());
         sent++;
      end while (tracker.frame_open());
      random_items += sent;
   endtask

   initial begin
      int w, h, frames;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.opcode = OP_PIXEL;
      req_bus.pixel_value = '0;
      csr_bus.valid = 1'b0;
      csr_bus.index = REG_IMAGE_WIDTH;
      csr_bus.data = '0;
      rsp_bus.ready = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // 3x2 frame: drain while idle, early drain, pixel while draining, equal centers
      set_frame(16'd3, 16'd2);
      send_item(OP_DRAIN, 8'hA5);
      send_item(OP_PIXEL, 8'hFF);
      send_item(OP_PIXEL, 8'h00);
      send_item(OP_PIXEL, 8'h80);
      send_item(OP_DRAIN, 8'hFF);
      send_item(OP_PIXEL, 8'hFF);
      send_item(OP_PIXEL, 8'h80);
      send_item(OP_DRAIN, 8'h00);
      send_item(OP_PIXEL, 8'd77);
      send_item(OP_DRAIN, 8'h00);
      send_item(OP_DRAIN, 8'h00);
      quiesce();
      set_frame(16'd1, 16'd1);
      send_item(OP_PIXEL, 8'd200);
      send_item(OP_DRAIN, 8'h00);
      send_item(OP_DRAIN, 8'h00);
      quiesce();
      // zero sizes act as one
      set_frame(16'd0, 16'd0);
      send_item(OP_PIXEL, 8'd9);
      send_item(OP_PIXEL, 8'd3);
      send_item(OP_DRAIN, 8'h00);
      quiesce();

      while (random_items < 1100) begin
         idle_pct = ($urandom_range(0, 4) == 0) ? 0 : 38;
         case ($urandom_range(0, 19))
            0: begin
               w = $urandom_range(49, 300);
               h = $urandom_range(1, 2);
            end
            1, 2, 3, 4, 5, 6, 7: begin
               w = $urandom_range(9, 48);
               h = $urandom_range(1, 5);
            end
            default: begin
               w = $urandom_range(1, 8);
               h = $urandom_range(1, 8);
            end
         endcase
         // upper data bits beyond the width field are dropped
         set_frame({3'($urandom), 13'(w)}, 16'(h));
         frames = $urandom_range(1, 3);
         repeat (frames) begin
            if ($urandom_range(0, 3) == 0)
               repeat ($urandom_range(1, 2)) send_item(OP_DRAIN, pick_pixel());
            run_frame($urandom_range(0, 2) == 0);
         end
         quiesce();
      end

      idle_pct = 38;
      set_frame(16'hE003, 16'h0000);
      run_frame(1'b0);
      quiesce();
      set_frame(16'h0000, 16'd3);
      run_frame(1'b1);
      quiesce();
      // long stretch with both sides always ready
      idle_pct = 0;
      set_frame(16'd64, 16'd4);
      run_frame(1'b0);
      quiesce();
      idle_pct = 38;

      if (tracker.codes_due.size() != 0)
         tracker.report($sformatf("%0d codes never came", tracker.codes_due.size()));
      if (tracker.errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #36000000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
